>>> hw/rtl/lgs_pkg.sv
`default_nettype none

package lgs_pkg;

    localparam int unsigned MAX_COLS_DEF = 128;
    localparam int unsigned MAX_ROWS_DEF = 128;

    localparam logic [1:0] KIND_WRITE   = 2'd0;
    localparam logic [1:0] KIND_READ    = 2'd1;
    localparam logic [1:0] KIND_ADVANCE = 2'd2;

    localparam logic [2:0] CFG_LIVE_LEVEL    = 3'd0;
    localparam logic [2:0] CFG_EDGE_MODE     = 3'd1;
    localparam logic [2:0] CFG_BIRTH_MASK    = 3'd2;
    localparam logic [2:0] CFG_SURVIVAL_MASK = 3'd3;
    localparam logic [2:0] CFG_COLS_IN_USE   = 3'd4;
    localparam logic [2:0] CFG_ROWS_IN_USE   = 3'd5;

    localparam logic [1:0] EDGE_CLAMP  = 2'd0;
    localparam logic [1:0] EDGE_MIRROR = 2'd1;

    typedef enum logic [1:0] {
        OP_WRITE   = 2'd0,
        OP_READ    = 2'd1,
        OP_ADVANCE = 2'd2
    } t_op;

    typedef struct packed {
        t_op        op;
        logic       in_store;
        logic [6:0] col;
        logic [6:0] row;
        logic [7:0] value;
    } t_cmd;

    typedef struct packed {
        logic [7:0] live_level;
        logic [1:0] edge_mode;
        logic [8:0] birth_mask;
        logic [8:0] survival_mask;
        logic [7:0] cols_in_use;
        logic [7:0] rows_in_use;
    } t_cfg;

endpackage

`default_nettype wire

>>> hw/rtl/life_generations_grid_step.sv
// Generations automaton over a grid of 8-bit cells held in a two-bank frame store.
// Input channel: push/full. Each beat carries kind, col, row and cell_value.
// Kind write stores a cell, read returns one, advance computes a generation;
// the unused kind is taken and dropped.
// Result channel: empty/pop, one read_value beat per read, in order.
// Configuration: i_cfg_valid/o_cfg_ready with index and data, ready always high;
// write it only while the block is idle.
// Write: handled in the idle state of the sequencer. Read: the sequencer pops it
// in the idle state and pushes the RAM data into the result queue from S_READ.
// Advance: every cell of the built store is visited; a cell inside the grid in
// use takes nine reads through the single read port of the frame RAM, one drain
// and one write, a cell outside it one read, one drain and one write.
// A two-entry command queue lets new beats be taken while the sequencer works.
// Reset: bank 0 is cleared one cell per cycle, every cell of the bank, with
// full held high. Configuration writes are still taken.
// When pop stays low the two-entry result queue fills and read commands wait
// in the command queue; full rises once that queue is full too.
`default_nettype none

module life_generations_grid_step
    import lgs_pkg::*;
#(
    parameter int unsigned MAX_COLS = MAX_COLS_DEF,
    parameter int unsigned MAX_ROWS = MAX_ROWS_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic [1:0] i_kind,
    input  wire logic [6:0] i_col,
    input  wire logic [6:0] i_row,
    input  wire logic [7:0] i_cell_value,
    output logic            empty,
    input  wire logic       pop,
    output logic [7:0]      o_read_value,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [2:0] i_cfg_index,
    input  wire logic [8:0] i_cfg_data
);

    t_cfg       r_cfg;
    t_cmd       cmd;
    logic       cmd_valid, cmd_pop, clearing;
    logic       res_full, res_push;
    logic [7:0] res_value;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.live_level    <= 8'd255;
            r_cfg.edge_mode     <= 2'd2;
            r_cfg.birth_mask    <= 9'd8;
            r_cfg.survival_mask <= 9'd12;
            r_cfg.cols_in_use   <= 8'd128;
            r_cfg.rows_in_use   <= 8'd128;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_LIVE_LEVEL:    r_cfg.live_level    <= i_cfg_data[7:0];
                CFG_EDGE_MODE:     r_cfg.edge_mode     <= i_cfg_data[1:0];
                CFG_BIRTH_MASK:    r_cfg.birth_mask    <= i_cfg_data;
                CFG_SURVIVAL_MASK: r_cfg.survival_mask <= i_cfg_data;
                CFG_COLS_IN_USE:   r_cfg.cols_in_use   <= i_cfg_data[7:0];
                CFG_ROWS_IN_USE:   r_cfg.rows_in_use   <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    lgs_front #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_kind       (i_kind),
        .i_col        (i_col),
        .i_row        (i_row),
        .i_cell_value (i_cell_value),
        .i_hold       (clearing),
        .o_full       (full),
        .o_cmd_valid  (cmd_valid),
        .o_cmd        (cmd),
        .i_cmd_pop    (cmd_pop)
    );

    lgs_back #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .i_cfg       (r_cfg),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res_value (res_value),
        .o_clearing  (clearing)
    );

    lgs_fifo #(
        .W (8),
        .D (2)
    ) u_resq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_value),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (o_read_value),
        .o_empty (empty)
    );

endmodule

`default_nettype wire

>>> hw/rtl/lgs_ram.sv
`default_nettype none

module lgs_ram #(
    parameter int unsigned W = 8,
    parameter int unsigned D = 256
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_we,
    input  wire logic [$clog2(D)-1:0] i_waddr,
    input  wire logic [W-1:0]         i_wdata,
    input  wire logic [$clog2(D)-1:0] i_raddr,
    output logic      [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> hw/rtl/lgs_fifo.sv
`default_nettype none

module lgs_fifo #(
    parameter int unsigned W = 8,
    parameter int unsigned D = 2
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire logic [W-1:0] i_data,
    output logic              o_full,
    input  wire logic         i_pop,
    output logic [W-1:0]      o_data,
    output logic              o_empty
);

    localparam int unsigned PW = (D > 1) ? $clog2(D) : 1;
    localparam int unsigned NW = $clog2(D + 1);

    logic [W-1:0]  r_mem [D];
    logic [PW-1:0] r_wp, r_rp;
    logic [NW-1:0] r_cnt;
    logic          do_push, do_pop;

    assign o_full  = (r_cnt == NW'(D));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == PW'(D - 1)) ? '0 : r_wp + PW'(1);
            end
            if (do_pop) begin
                r_rp <= (r_rp == PW'(D - 1)) ? '0 : r_rp + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + NW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - NW'(1);
            end
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/lgs_front.sv
`default_nettype none

module lgs_front
    import lgs_pkg::*;
#(
    parameter int unsigned MAX_COLS = MAX_COLS_DEF,
    parameter int unsigned MAX_ROWS = MAX_ROWS_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_push,
    input  wire logic [1:0] i_kind,
    input  wire logic [6:0] i_col,
    input  wire logic [6:0] i_row,
    input  wire logic [7:0] i_cell_value,
    input  wire logic       i_hold,
    output logic            o_full,
    output logic            o_cmd_valid,
    output t_cmd            o_cmd,
    input  wire logic       i_cmd_pop
);

    t_cmd cmd;
    logic q_full, q_empty, keep;
    logic [$bits(t_cmd)-1:0] q_out;

    always_comb begin
        cmd.in_store = (32'(i_col) < MAX_COLS) && (32'(i_row) < MAX_ROWS);
        cmd.col      = i_col;
        cmd.row      = i_row;
        cmd.value    = i_cell_value;
        keep         = 1'b1;
        unique case (i_kind)
            KIND_WRITE:   cmd.op = OP_WRITE;
            KIND_READ:    cmd.op = OP_READ;
            KIND_ADVANCE: cmd.op = OP_ADVANCE;
            default: begin
                cmd.op = OP_WRITE;
                keep   = 1'b0;
            end
        endcase
    end

    assign o_full      = q_full || i_hold;
    assign o_cmd_valid = !q_empty;
    assign o_cmd       = t_cmd'(q_out);

    lgs_fifo #(
        .W ($bits(t_cmd)),
        .D (2)
    ) u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push && !o_full && keep),
        .i_data  (cmd),
        .o_full  (q_full),
        .i_pop   (i_cmd_pop),
        .o_data  (q_out),
        .o_empty (q_empty)
    );

endmodule

`default_nettype wire

>>> hw/rtl/lgs_back.sv
`default_nettype none

module lgs_back
    import lgs_pkg::*;
#(
    parameter int unsigned MAX_COLS = MAX_COLS_DEF,
    parameter int unsigned MAX_ROWS = MAX_ROWS_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cmd_valid,
    input  wire t_cmd       i_cmd,
    output logic            o_cmd_pop,
    input  wire t_cfg       i_cfg,
    input  wire logic       i_res_full,
    output logic            o_res_push,
    output logic [7:0]      o_res_value,
    output logic            o_clearing
);

    localparam int unsigned CW    = $clog2(MAX_COLS);
    localparam int unsigned RW    = $clog2(MAX_ROWS);
    localparam int unsigned WW    = $clog2(MAX_COLS + 1);
    localparam int unsigned HW    = $clog2(MAX_ROWS + 1);
    localparam int unsigned BANK  = MAX_COLS * MAX_ROWS;
    localparam int unsigned DEPTH = 2 * BANK;
    localparam int unsigned AW    = $clog2(DEPTH);

    typedef enum logic [5:0] {
        S_CLEAR    = 6'b000001,
        S_IDLE     = 6'b000010,
        S_READ     = 6'b000100,
        S_ADV_RD   = 6'b001000,
        S_ADV_LAST = 6'b010000,
        S_ADV_WR   = 6'b100000
    } t_state;

    t_state        r_state, n_state;
    logic          r_bank, n_bank;
    logic [RW-1:0] r_r, n_r;
    logic [CW-1:0] r_c, n_c;
    logic [3:0]    r_k, n_k;
    logic [3:0]    r_cnt, n_cnt;
    logic [7:0]    r_s, n_s;
    logic          r_pend, n_pend;
    logic          r_ok, n_ok;
    logic          r_ctr, n_ctr;
    logic          r_rin, n_rin;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [7:0]    wdata, rdata;

    logic [WW-1:0] w;
    logic [HW-1:0] h;
    logic [7:0]    lvl;
    logic          in_grid, last_cell;
    logic [RW-1:0] rm, rp, nr;
    logic [CW-1:0] cm, cp, nc;
    logic          rm_ok, rp_ok, cm_ok, cp_ok, step_ok;
    logic [7:0]    s_new;

    function automatic logic [AW-1:0] cell_addr(input logic bank, input logic [AW-1:0] row,
                                                input logic [AW-1:0] col);
        cell_addr = (bank ? AW'(BANK) : '0) + row * AW'(MAX_COLS) + col;
    endfunction

    always_comb begin
        w = (32'(i_cfg.cols_in_use) < 2) ? WW'(2) :
            (32'(i_cfg.cols_in_use) > MAX_COLS) ? WW'(MAX_COLS) : WW'(i_cfg.cols_in_use);
        h = (32'(i_cfg.rows_in_use) < 2) ? HW'(2) :
            (32'(i_cfg.rows_in_use) > MAX_ROWS) ? HW'(MAX_ROWS) : HW'(i_cfg.rows_in_use);
        lvl = (i_cfg.live_level == 8'd0) ? 8'd1 : i_cfg.live_level;
        in_grid   = (HW'(r_r) < h) && (WW'(r_c) < w);
        last_cell = (r_c == CW'(MAX_COLS - 1)) && (r_r == RW'(MAX_ROWS - 1));

        rm_ok = 1'b1;
        rm    = r_r - RW'(1);
        if (r_r == '0) begin
            rm_ok = (i_cfg.edge_mode != EDGE_CLAMP);
            rm    = (i_cfg.edge_mode == EDGE_MIRROR) ? RW'(1) : RW'(h - HW'(1));
        end
        rp_ok = 1'b1;
        rp    = r_r + RW'(1);
        if (HW'(r_r) + HW'(1) >= h) begin
            rp_ok = (i_cfg.edge_mode != EDGE_CLAMP);
            rp    = (i_cfg.edge_mode == EDGE_MIRROR) ? RW'(h - HW'(2)) : '0;
        end
        cm_ok = 1'b1;
        cm    = r_c - CW'(1);
        if (r_c == '0) begin
            cm_ok = (i_cfg.edge_mode != EDGE_CLAMP);
            cm    = (i_cfg.edge_mode == EDGE_MIRROR) ? CW'(1) : CW'(w - WW'(1));
        end
        cp_ok = 1'b1;
        cp    = r_c + CW'(1);
        if (WW'(r_c) + WW'(1) >= w) begin
            cp_ok = (i_cfg.edge_mode != EDGE_CLAMP);
            cp    = (i_cfg.edge_mode == EDGE_MIRROR) ? CW'(w - WW'(2)) : '0;
        end

        case (r_k)
            4'd1:    begin nr = rm;  nc = cm;  step_ok = rm_ok && cm_ok; end
            4'd2:    begin nr = rm;  nc = r_c; step_ok = rm_ok;          end
            4'd3:    begin nr = rm;  nc = cp;  step_ok = rm_ok && cp_ok; end
            4'd4:    begin nr = r_r; nc = cm;  step_ok = cm_ok;          end
            4'd5:    begin nr = r_r; nc = cp;  step_ok = cp_ok;          end
            4'd6:    begin nr = rp;  nc = cm;  step_ok = rp_ok && cm_ok; end
            4'd7:    begin nr = rp;  nc = r_c; step_ok = rp_ok;          end
            4'd8:    begin nr = rp;  nc = cp;  step_ok = rp_ok && cp_ok; end
            default: begin nr = r_r; nc = r_c; step_ok = 1'b1;           end
        endcase

        s_new = r_s;
        if (in_grid) begin
            if (r_s < lvl) begin
                if (i_cfg.birth_mask[r_cnt]) begin
                    s_new = lvl;
                end else if (r_s != 8'd0) begin
                    s_new = r_s - 8'd1;
                end
            end else if (!i_cfg.survival_mask[r_cnt]) begin
                s_new = r_s - 8'd1;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        n_bank  = r_bank;
        n_r     = r_r;
        n_c     = r_c;
        n_k     = r_k;
        n_cnt   = r_cnt;
        n_s     = r_s;
        n_pend  = 1'b0;
        n_ok    = r_ok;
        n_ctr   = r_ctr;
        n_rin   = r_rin;
        we      = 1'b0;
        waddr   = cell_addr(!r_bank, AW'(r_r), AW'(r_c));
        wdata   = s_new;
        raddr   = cell_addr(r_bank, AW'(nr), AW'(nc));
        o_cmd_pop   = 1'b0;
        o_res_push  = 1'b0;
        o_res_value = r_rin ? rdata : 8'd0;

        if (r_pend) begin
            if (r_ctr) begin
                n_s = rdata;
            end else if (r_ok && rdata >= lvl) begin
                n_cnt = r_cnt + 4'd1;
            end
        end

        unique case (r_state)
            S_CLEAR: begin
                we    = 1'b1;
                waddr = cell_addr(1'b0, AW'(r_r), AW'(r_c));
                wdata = 8'd0;
                n_c   = r_c + CW'(1);
                if (r_c == CW'(MAX_COLS - 1)) begin
                    n_c = '0;
                    n_r = r_r + RW'(1);
                    if (r_r == RW'(MAX_ROWS - 1)) begin
                        n_r     = '0;
                        n_state = S_IDLE;
                    end
                end
            end
            S_IDLE: begin
                raddr = cell_addr(r_bank, AW'(i_cmd.row), AW'(i_cmd.col));
                waddr = raddr;
                wdata = i_cmd.value;
                if (i_cmd_valid) begin
                    unique case (i_cmd.op)
                        OP_WRITE: begin
                            o_cmd_pop = 1'b1;
                            we        = i_cmd.in_store;
                        end
                        OP_READ: begin
                            if (!i_res_full) begin
                                o_cmd_pop = 1'b1;
                                n_rin     = i_cmd.in_store;
                                n_state   = S_READ;
                            end
                        end
                        OP_ADVANCE: begin
                            o_cmd_pop = 1'b1;
                            n_r       = '0;
                            n_c       = '0;
                            n_k       = '0;
                            n_cnt     = '0;
                            n_state   = S_ADV_RD;
                        end
                        default: ;
                    endcase
                end
            end
            S_READ: begin
                o_res_push = 1'b1;
                n_state    = S_IDLE;
            end
            S_ADV_RD: begin
                n_pend = 1'b1;
                n_ok   = step_ok;
                n_ctr  = (r_k == 4'd0);
                n_k    = r_k + 4'd1;
                if (r_k == 4'd8 || !in_grid) begin
                    n_state = S_ADV_LAST;
                end
            end
            S_ADV_LAST: begin
                n_state = S_ADV_WR;
            end
            S_ADV_WR: begin
                we      = 1'b1;
                n_k     = '0;
                n_cnt   = '0;
                n_state = S_ADV_RD;
                n_c     = r_c + CW'(1);
                if (r_c == CW'(MAX_COLS - 1)) begin
                    n_c = '0;
                    n_r = r_r + RW'(1);
                end
                if (last_cell) begin
                    n_r     = '0;
                    n_bank  = !r_bank;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_clearing = (r_state == S_CLEAR);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_bank  <= 1'b0;
            r_r     <= '0;
            r_c     <= '0;
            r_k     <= '0;
            r_cnt   <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_bank  <= n_bank;
            r_r     <= n_r;
            r_c     <= n_c;
            r_k     <= n_k;
            r_cnt   <= n_cnt;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s   <= n_s;
        r_ok  <= n_ok;
        r_ctr <= n_ctr;
        r_rin <= n_rin;
    end

    lgs_ram #(
        .W (8),
        .D (DEPTH)
    ) u_frames (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

endmodule

`default_nettype wire

>>> hw/rtl/lgs_chk.sv
`default_nettype none

module lgs_chk (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       full,
    input wire logic       empty,
    input wire logic       pop,
    input wire logic [7:0] o_read_value
);

    // no result survives reset
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    // clearing pass holds the input off after reset
    a_reset_full: assert property (@(posedge i_clk) !i_rst_n |=> full ##1 full)
        else $error("input taken during clearing pass");

    // a waiting result holds until popped
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_read_value)))
        else $error("waiting result lost or changed");

endmodule

bind life_generations_grid_step lgs_chk u_chk (.*);

`default_nettype wire

>>> sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import lgs_pkg::*;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int GRID_CELLS = MAX_COLS_DEF * MAX_ROWS_DEF;

    class cell_scoreboard;
        logic [7:0] frame [2][GRID_CELLS];
        bit         bank;
        logic [7:0] live_level = 8'd255;
        logic [1:0] edge_mode = 2'd2;
        logic [8:0] birth_mask = 9'd8;
        logic [8:0] survival_mask = 9'd12;
        logic [7:0] cols_in_use = 8'd128;
        logic [7:0] rows_in_use = 8'd128;
        logic [7:0] pending_reads [$];
        int         errors;
        int         reads_checked;
        int         generations;

        function new();
            for (int i = 0; i < GRID_CELLS; i++) begin
                frame[0][i] = 8'd0;
                frame[1][i] = 8'd0;
            end
        endfunction

        function void note_config(logic [2:0] idx, logic [8:0] data);
            case (idx)
                CFG_LIVE_LEVEL:    live_level = data[7:0];
                CFG_EDGE_MODE:     edge_mode = data[1:0];
                CFG_BIRTH_MASK:    birth_mask = data;
                CFG_SURVIVAL_MASK: survival_mask = data;
                CFG_COLS_IN_USE:   cols_in_use = data[7:0];
                CFG_ROWS_IN_USE:   rows_in_use = data[7:0];
                default: ;
            endcase
        endfunction

        function int span(logic [7:0] v, int top);
            if (v < 2) return 2;
            if (v > top) return top;
            return v;
        endfunction

        // neighbour coordinate; 0 when clamped off the grid
        function bit neighbour(int p, int d, int n, output int q);
            q = p + d;
            if (d < 0 && p == 0) begin
                if (edge_mode == EDGE_CLAMP) return 0;
                q = (edge_mode == EDGE_MIRROR) ? 1 : n - 1;
            end else if (d > 0 && p + 1 >= n) begin
                if (edge_mode == EDGE_CLAMP) return 0;
                q = (edge_mode == EDGE_MIRROR) ? n - 2 : 0;
            end
            return 1;
        endfunction

        function void step_generation();
            int w;
            int h;
            int lvl;
            int n;
            int s;
            int nr;
            int nc;
            bit nxt;
            w = span(cols_in_use, MAX_COLS_DEF);
            h = span(rows_in_use, MAX_ROWS_DEF);
            lvl = (live_level == 0) ? 1 : live_level;
            nxt = ~bank;
            frame[nxt] = frame[bank];
            for (int r = 0; r < h; r++) begin
                for (int c = 0; c < w; c++) begin
                    n = 0;
                    s = frame[bank][r * MAX_COLS_DEF + c];
                    for (int dr = -1; dr <= 1; dr++) begin
                        if (neighbour(r, dr, h, nr)) begin
                            for (int dc = -1; dc <= 1; dc++) begin
                                if (!(dr == 0 && dc == 0) && neighbour(c, dc, w, nc))
                                    if (frame[bank][nr * MAX_COLS_DEF + nc] >= lvl) n++;
                            end
                        end
                    end
                    if (n > 8) n = 8;
                    if (s < lvl) begin
                        if (birth_mask[n]) s = lvl;
                        else if (s > 0) s--;
                    end else if (!survival_mask[n]) begin
                        s--;
                    end
                    frame[nxt][r * MAX_COLS_DEF + c] = s[7:0];
                end
            end
            bank = nxt;
            generations++;
        endfunction

        function void note_item(logic [1:0] kind, logic [6:0] col, logic [6:0] row,
                                logic [7:0] value);
            case (kind)
                KIND_WRITE:   frame[bank][{row, col}] = value;
                KIND_READ:    pending_reads.push_back(frame[bank][{row, col}]);
                KIND_ADVANCE: step_generation();
                default: ;
            endcase
        endfunction

        function void check_value(logic [7:0] got);
            logic [7:0] want;
            if (pending_reads.size() == 0) begin
                $display("%0t: unexpected read_value beat, actual %0d", $time, got);
                errors++;
                return;
            end
            want = pending_reads.pop_front();
            reads_checked++;
            if (got !== want) begin
                $display("%0t: read_value mismatch, expected %0d actual %0d",
                         $time, want, got);
                errors++;
            end
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       push = 1'b0;
    logic [1:0] i_kind = KIND_WRITE;
    logic [6:0] i_col = '0;
    logic [6:0] i_row = '0;
    logic [7:0] i_cell_value = '0;
    logic       pop = 1'b0;
    logic       i_cfg_valid = 1'b0;
    logic [2:0] i_cfg_index = CFG_LIVE_LEVEL;
    logic [8:0] i_cfg_data = '0;
    logic       full;
    logic       empty;
    logic [7:0] o_read_value;
    logic       o_cfg_ready;

    cell_scoreboard sb = new();
    int  burst_left;
    int  phases;
    logic [11:0] stall_cnt = '0;

    life_generations_grid_step u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .push(push), .full(full),
        .i_kind(i_kind), .i_col(i_col), .i_row(i_row), .i_cell_value(i_cell_value),
        .empty(empty), .pop(pop), .o_read_value(o_read_value),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #100ms;
        $display("Simulation FAILED");
        $finish;
    end

    // receiver stall pattern
    always @(posedge i_clk) begin
        stall_cnt <= stall_cnt + 1'b1;
        case (stall_cnt[9:8])
            2'd0: pop <= 1'b1;
            2'd1: pop <= 1'($urandom_range(0, 1));
            2'd2: pop <= ($urandom_range(0, 7) == 0);
            default: pop <= stall_cnt[3];
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) sb.check_value(o_read_value);
    end

    task automatic send_beat(logic [1:0] kind, logic [6:0] col, logic [6:0] row,
                             logic [7:0] value);
        if (burst_left == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 30 : $urandom_range(1, 8);
        end
        burst_left--;
        push <= 1'b1;
        i_kind <= kind;
        i_col <= col;
        i_row <= row;
        i_cell_value <= value;
        do @(posedge i_clk); while (full);
        sb.note_item(kind, col, row, value);
    endtask

    // read fence: once its beat returns the sequencer has finished everything before it
    task automatic settle();
        send_beat(KIND_READ, 7'($urandom), 7'($urandom), 8'($urandom));
        push <= 1'b0;
        burst_left = 0;
        while (sb.pending_reads.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [8:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.note_config(idx, data);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_rules(logic [8:0] lvl, logic [8:0] edge_sel, logic [8:0] birth,
                             logic [8:0] surv, logic [8:0] cols, logic [8:0] rows);
        settle();
        write_reg(CFG_LIVE_LEVEL, lvl);
        write_reg(CFG_EDGE_MODE, edge_sel);
        write_reg(CFG_BIRTH_MASK, birth);
        write_reg(CFG_SURVIVAL_MASK, surv);
        write_reg(CFG_COLS_IN_USE, cols);
        write_reg(CFG_ROWS_IN_USE, rows);
        phases++;
    endtask

    function automatic logic [7:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 8'd0;
            1: return 8'd255;
            2, 3: return sb.live_level;
            4: return sb.live_level - 8'd1;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic random_phase(int beats);
        int w;
        int h;
        int kind_roll;
        logic [6:0] col;
        logic [6:0] row;
        w = sb.span(sb.cols_in_use, MAX_COLS_DEF);
        h = sb.span(sb.rows_in_use, MAX_ROWS_DEF);
        for (int i = 0; i < beats; i++) begin
            if ($urandom_range(0, 5) != 0) begin
                col = 7'($urandom_range(0, (w > 127) ? 127 : w));
                row = 7'($urandom_range(0, (h > 127) ? 127 : h));
            end else begin
                col = 7'($urandom);
                row = 7'($urandom);
            end
            kind_roll = $urandom_range(0, 19);
            if (i == beats / 2 || i == beats - 2)
                send_beat(KIND_ADVANCE, col, row, 8'($urandom));
            else if (kind_roll == 0)
                send_beat(KIND_UNUSED, col, row, 8'($urandom));
            else if (kind_roll < 8)
                send_beat(KIND_READ, col, row, 8'($urandom));
            else
                send_beat(KIND_WRITE, col, row, pick_value());
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // extremes at reset rules, then a full-size generation on the torus
        send_beat(KIND_READ, 7'd127, 7'd127, 8'd0);
        send_beat(KIND_WRITE, 7'd0, 7'd0, 8'd255);
        send_beat(KIND_WRITE, 7'd127, 7'd127, 8'd255);
        send_beat(KIND_WRITE, 7'd127, 7'd0, 8'd255);
        send_beat(KIND_WRITE, 7'd1, 7'd5, 8'd0);
        send_beat(KIND_WRITE, 7'd2, 7'd5, 8'd255);
        send_beat(KIND_WRITE, 7'd3, 7'd5, 8'd255);
        send_beat(KIND_WRITE, 7'd4, 7'd5, 8'd255);
        send_beat(KIND_WRITE, 7'd64, 7'd64, 8'd200);
        send_beat(KIND_UNUSED, 7'd3, 7'd3, 8'd77);
        send_beat(KIND_READ, 7'd0, 7'd0, 8'd0);
        send_beat(KIND_READ, 7'd127, 7'd127, 8'd0);
        send_beat(KIND_ADVANCE, 7'd0, 7'd0, 8'd0);
        for (int c = 1; c <= 4; c++) send_beat(KIND_READ, 7'(c), 7'd5, 8'd0);
        send_beat(KIND_READ, 7'd3, 7'd4, 8'd0);
        send_beat(KIND_READ, 7'd3, 7'd6, 8'd0);
        send_beat(KIND_READ, 7'd64, 7'd64, 8'd0);
        send_beat(KIND_READ, 7'd0, 7'd127, 8'd0);

        set_rules(9'd1, 9'(EDGE_CLAMP), 9'h1FF, 9'h000, 9'd2, 9'd2);
        random_phase(14);
        set_rules(9'd0, 9'(EDGE_MIRROR), 9'h0AA, 9'h155, 9'd5, 9'd4);
        random_phase(14);
        set_rules(9'd128, 9'd3, 9'd8, 9'd12, 9'd7, 9'd9);
        random_phase(14);
        set_rules(9'd255, 9'(EDGE_CLAMP), 9'h100, 9'h1FF, 9'd0, 9'd255);
        random_phase(10);
        set_rules(9'($urandom_range(1, 255)), 9'($urandom_range(0, 3)), 9'($urandom),
                  9'($urandom), 9'($urandom_range(2, 12)), 9'($urandom_range(2, 12)));
        random_phase(14);
        set_rules(9'($urandom_range(1, 255)), 9'(EDGE_MIRROR), 9'($urandom), 9'($urandom),
                  9'd3, 9'd2);
        random_phase(14);

        push <= 1'b0;
        while (sb.pending_reads.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);

        $display("%0d read beats checked over %0d generations and %0d rule sets",
                 sb.reads_checked, sb.generations, phases + 1);
        if (sb.errors == 0 && sb.pending_reads.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
